### rtl/core/tcce_pkg.sv
// Shared types and constants of the TCP client connection engine.
// Used by every module in rtl/core; has no dependencies of its own.
package tcce_pkg;

	// TCP flag bits
	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	localparam int MIN_FRAME_LEN  = 54;   // eth + ip + minimal tcp header
	localparam int ETH_IP_HDR_LEN = 34;   // eth + ip header bytes
	localparam int TCP_HDR_LEN    = 20;
	localparam int PROTO_TCP      = 6;
	localparam int MAX_PAYLOAD    = 1480;
	localparam logic [7:0] DATA_OFFSET_BYTE = 8'(5 << 4);   // 5 words, no options

	localparam logic [31:0] RST_LOCAL_IP    = 32'h0A00_020F;
	localparam logic [31:0] RST_REMOTE_IP   = 32'h0A00_0202;
	localparam logic [15:0] RST_LOCAL_PORT  = 16'd12345;
	localparam logic [15:0] RST_REMOTE_PORT = 16'd80;
	localparam logic [31:0] RST_INITIAL_SEQ = 32'h1234_5678;
	localparam logic [15:0] RST_RECV_WINDOW = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_OPEN = 2'd0,
		ACT_RX   = 2'd1,
		ACT_SEND = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_LOCAL_IP    = 3'd0,
		REG_REMOTE_IP   = 3'd1,
		REG_LOCAL_PORT  = 3'd2,
		REG_REMOTE_PORT = 3'd3,
		REG_INITIAL_SEQ = 3'd4,
		REG_RECV_WINDOW = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [31:0] remote_ip;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [31:0] initial_seq;
		logic [15:0] recv_window;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  rx_flags;
		logic [31:0] rx_seq;
		logic [3:0]  rx_hdr_words;
		logic [15:0] rx_frame_len;
		logic [10:0] send_len;
		logic [15:0] payload_sum;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [10:0] tx_seg_len;
		logic [15:0] tx_checksum;
		logic        rx_payload_valid;
		logic [6:0]  rx_payload_offset;
		logic [15:0] rx_payload_len;
		logic        became_established;
		logic [1:0]  conn_status;
	} result_t;

endpackage

### rtl/core/tcce_cfg.sv
// Configuration register file of the TCP client connection engine.
// Depends on tcce_pkg for the register codes and the cfg_t layout.
module tcce_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	output tcce_pkg::cfg_t cfg
);

	tcce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip    <= tcce_pkg::RST_LOCAL_IP;
			cfg_q.remote_ip   <= tcce_pkg::RST_REMOTE_IP;
			cfg_q.local_port  <= tcce_pkg::RST_LOCAL_PORT;
			cfg_q.remote_port <= tcce_pkg::RST_REMOTE_PORT;
			cfg_q.initial_seq <= tcce_pkg::RST_INITIAL_SEQ;
			cfg_q.recv_window <= tcce_pkg::RST_RECV_WINDOW;
		end else if (wr_en) begin
			case (wr_index)
				tcce_pkg::REG_LOCAL_IP:    cfg_q.local_ip    <= wr_data;
				tcce_pkg::REG_REMOTE_IP:   cfg_q.remote_ip   <= wr_data;
				tcce_pkg::REG_LOCAL_PORT:  cfg_q.local_port  <= wr_data[15:0];
				tcce_pkg::REG_REMOTE_PORT: cfg_q.remote_port <= wr_data[15:0];
				tcce_pkg::REG_INITIAL_SEQ: cfg_q.initial_seq <= wr_data;
				tcce_pkg::REG_RECV_WINDOW: cfg_q.recv_window <= wr_data[15:0];
				default: ;   // unmapped index: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/tcce_csum.sv
// TCP checksum over pseudo-header, fixed 20-byte header and payload sum.
// Pure adder tree plus two end-around folds; depends on tcce_pkg.
module tcce_csum (
	input  tcce_pkg::cfg_t cfg,
	input  logic [7:0]  flags,
	input  logic [31:0] seq,
	input  logic [31:0] ack,
	input  logic [10:0] pay_len,
	input  logic [15:0] pay_sum,
	output logic [15:0] checksum
);

	logic [15:0] pseudo_len;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	always_comb begin
		pseudo_len = 16'(tcce_pkg::TCP_HDR_LEN) + {5'b0, pay_len};
		// 15 terms of 16 bits: total stays below 2^20
		sum = 20'(cfg.local_ip[31:16]) + 20'(cfg.local_ip[15:0])
			+ 20'(cfg.remote_ip[31:16]) + 20'(cfg.remote_ip[15:0])
			+ 20'(tcce_pkg::PROTO_TCP) + 20'(pseudo_len)
			+ 20'(cfg.local_port) + 20'(cfg.remote_port)
			+ 20'(seq[31:16]) + 20'(seq[15:0])
			+ 20'(ack[31:16]) + 20'(ack[15:0])
			+ 20'({tcce_pkg::DATA_OFFSET_BYTE, flags})
			+ 20'(cfg.recv_window) + 20'(pay_sum);
		fold1    = {1'b0, sum[15:0]} + {13'b0, sum[19:16]};
		fold2    = fold1[15:0] + {15'b0, fold1[16]};
		checksum = ~fold2;
	end

endmodule

### rtl/core/tcce_event.sv
// Connection state machine and per-event result logic.
// Holds conn state, send_next and recv_next; uses tcce_csum and tcce_pkg.
module tcce_event (
	input  logic              clk,
	input  logic              arst_n,
	input  tcce_pkg::cfg_t    cfg,
	input  tcce_pkg::item_t   item,
	input  logic              fire,      // item leaves the input stage
	output tcce_pkg::result_t res
);

	typedef enum logic [1:0] {
		ST_CLOSED   = 2'd0,
		ST_SYN_SENT = 2'd1,
		ST_ESTAB    = 2'd2,
		ST_LAST_ACK = 2'd3
	} conn_state_t;

	conn_state_t state_q, state_d;
	logic [31:0] send_next_q, send_next_d;
	logic [31:0] recv_next_q, recv_next_d;

	logic        emit;
	logic [7:0]  e_flags;
	logic [31:0] e_seq;
	logic [31:0] e_ack;
	logic [10:0] e_len;
	logic [15:0] e_psum;
	logic [15:0] csum;
	logic [16:0] data_len;
	logic [6:0]  pay_off;
	logic        frame_ok;

	tcce_csum u_csum (
		.cfg      (cfg),
		.flags    (e_flags),
		.seq      (e_seq),
		.ack      (e_ack),
		.pay_len  (e_len),
		.pay_sum  (e_psum),
		.checksum (csum)
	);

	always_comb begin
		state_d     = state_q;
		send_next_d = send_next_q;
		recv_next_d = recv_next_q;
		emit        = 1'b0;
		e_flags     = '0;
		e_seq       = '0;
		e_ack       = '0;
		e_len       = '0;
		e_psum      = '0;
		res         = '0;

		frame_ok = item.rx_frame_len >= 16'(tcce_pkg::MIN_FRAME_LEN);
		pay_off  = 7'(tcce_pkg::ETH_IP_HDR_LEN) + {1'b0, item.rx_hdr_words, 2'b00};
		data_len = {1'b0, item.rx_frame_len} - 17'(tcce_pkg::ETH_IP_HDR_LEN)
			- {11'b0, item.rx_hdr_words, 2'b00};

		case (item.action)
			tcce_pkg::ACT_OPEN: begin
				if (state_q == ST_CLOSED) begin
					emit        = 1'b1;
					e_flags     = tcce_pkg::FL_SYN;
					e_seq       = cfg.initial_seq;
					send_next_d = cfg.initial_seq + 32'd1;
					state_d     = ST_SYN_SENT;
				end
			end
			tcce_pkg::ACT_RX: begin
				if (frame_ok) begin
					case (state_q)
						ST_SYN_SENT: begin
							if ((item.rx_flags & (tcce_pkg::FL_SYN | tcce_pkg::FL_ACK))
								== (tcce_pkg::FL_SYN | tcce_pkg::FL_ACK)) begin
								recv_next_d = item.rx_seq + 32'd1;
								emit        = 1'b1;
								e_flags     = tcce_pkg::FL_ACK;
								e_seq       = send_next_q;
								e_ack       = item.rx_seq + 32'd1;
								state_d     = ST_ESTAB;
								res.became_established = 1'b1;
							end
						end
						ST_ESTAB: begin
							if ((item.rx_flags & tcce_pkg::FL_FIN) != 8'd0) begin
								recv_next_d = item.rx_seq + 32'd1;
								emit        = 1'b1;
								e_flags     = tcce_pkg::FL_ACK | tcce_pkg::FL_FIN;
								e_seq       = send_next_q;
								e_ack       = item.rx_seq + 32'd1;
								state_d     = ST_LAST_ACK;
							end else if (!data_len[16] && data_len != 17'd0) begin
								res.rx_payload_valid  = 1'b1;
								res.rx_payload_offset = pay_off;
								res.rx_payload_len    = data_len[15:0];
							end
						end
						ST_LAST_ACK: begin
							if ((item.rx_flags & tcce_pkg::FL_ACK) != 8'd0)
								state_d = ST_CLOSED;
						end
						default: ;   // closed: ignore
					endcase
				end
			end
			tcce_pkg::ACT_SEND: begin
				if (state_q == ST_ESTAB && 32'(item.send_len) <= tcce_pkg::MAX_PAYLOAD) begin
					emit        = 1'b1;
					e_flags     = tcce_pkg::FL_ACK | tcce_pkg::FL_PSH;
					e_seq       = send_next_q;
					e_ack       = recv_next_q;
					e_len       = item.send_len;
					e_psum      = item.payload_sum;
					send_next_d = send_next_q + {21'b0, item.send_len};
				end
			end
			default: ;   // unused action code
		endcase

		if (emit) begin
			res.tx_valid    = 1'b1;
			res.tx_flags    = e_flags;
			res.tx_seq      = e_seq;
			res.tx_ack      = e_ack;
			res.tx_seg_len  = 11'(tcce_pkg::TCP_HDR_LEN) + e_len;
			res.tx_checksum = csum;
		end
		res.conn_status = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLOSED;
			send_next_q <= '0;
			recv_next_q <= '0;
		end else if (fire) begin
			state_q     <= state_d;
			send_next_q <= send_next_d;
			recv_next_q <= recv_next_d;
		end
	end

endmodule

### rtl/core/tcp_client_connection_engine.sv
// TCP client connection engine: one event in, one result out.
// The input register loads at the accepting edge and the result register when
//   the event advances, which m_tready low with a result waiting can hold back.
// Throughput: one event per cycle while the output is not stalled; the connection
//   state update is combinational between the input and result registers.
// Reset (arst_n low): connection closed, send/recv sequence numbers zero, config
//   registers at their defaults, both pipeline stages empty.
// Depends on tcce_pkg, tcce_cfg, tcce_event (with tcce_csum).
module tcp_client_connection_engine (
	input  logic         clk,
	input  logic         arst_n,

	// event stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	// [7:0] rx_flags, [39:8] rx_seq, [43:40] rx_hdr_words, [59:44] rx_frame_len,
	// [70:60] send_len, [86:71] payload_sum, [87] zero pad
	input  logic [87:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,

	// result stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] tx_flags, [39:8] tx_seq, [71:40] tx_ack, [82:72] tx_seg_len,
	// [98:83] tx_checksum, [105:99] rx_payload_offset, [121:106] rx_payload_len,
	// [123:122] conn_status, [127:124] zero pad
	output logic [127:0] m_tdata,
	// [0] tx_valid, [1] rx_payload_valid, [2] became_established
	output logic [2:0]   m_tuser,

	// config write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	tcce_pkg::cfg_t    cfg;
	tcce_pkg::item_t   item_s1;
	tcce_pkg::result_t res_comb;
	tcce_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s1;   // stage 1 moves into the result register

	// Config writes always land; the host must write only while idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	tcce_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Result register is free when empty or being drained this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	// Input stage takes a new transaction when empty or emptying, so one
	// event can still enter while a finished result waits downstream.
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action       <= s_tuser;
			item_s1.rx_flags     <= s_tdata[7:0];
			item_s1.rx_seq       <= s_tdata[39:8];
			item_s1.rx_hdr_words <= s_tdata[43:40];
			item_s1.rx_frame_len <= s_tdata[59:44];
			item_s1.send_len     <= s_tdata[70:60];
			item_s1.payload_sum  <= s_tdata[86:71];
		end
	end

	// State update and result for the event in stage 1; state commits
	// only when the event moves on.
	tcce_event u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (adv_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res_comb;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0,
		res_s2.conn_status,
		res_s2.rx_payload_len,
		res_s2.rx_payload_offset,
		res_s2.tx_checksum,
		res_s2.tx_seg_len,
		res_s2.tx_ack,
		res_s2.tx_seq,
		res_s2.tx_flags};
	assign m_tuser  = {res_s2.became_established, res_s2.rx_payload_valid, res_s2.tx_valid};

endmodule
